FILE: rtl/hierarchical_timer_wheel_assert.svh
// Assertion macros shared by the timer wheel RTL.
// Depends on nothing; included inside module bodies.
`ifndef HIERARCHICAL_TIMER_WHEEL_ASSERT_SVH
`define HIERARCHICAL_TIMER_WHEEL_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define HTW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define HTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/htw_pkg.sv
// Types and result codes of the hierarchical timer wheel.
// Depends on nothing.
package htw_pkg;
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   localparam logic [2:0] KIND_DONE     = 3'd0;
   localparam logic [2:0] KIND_EXPIRED  = 3'd1;
   localparam logic [2:0] KIND_REJECTED = 3'd2;
   localparam logic [2:0] KIND_NONE     = 3'd3;
   localparam logic [2:0] KIND_IDLE     = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  timer_id;
      logic [23:0] delay_ticks;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] expired_id;
      logic       is_last;
   } rsp_type;
endpackage

FILE: rtl/hierarchical_timer_wheel.sv
// Top level of the hierarchical timer wheel: sequencer, entry memory and
// result register. Depends on htw_pkg and hierarchical_timer_wheel_assert.svh.
//
//  channel | dir | payload  | handshake
//  req     | in  | req_type | req_valid / req_stall
//  rsp     | out | rsp_type | rsp_valid / rsp_stall
//
// An add or delete registers its result when it is accepted, and the next
// transaction goes in once that result is taken. A tick scans the pool once
// for level 0 and once more for every cascaded level: each entry is read
// (S_RD) and evaluated (S_EVAL), each expired timer passes through S_SEND,
// and S_NEXTLVL moves up a level. Entries are read one at a time through
// the single read port of the entry memory. Reset is synchronous and clears
// the busy bits, slot pointers and tick counter. Each result waits in the
// output register while rsp_stall is high; the scan holds when a further
// expiry finds it still occupied.
module hierarchical_timer_wheel #(
   parameter int NUM_LEVELS = 4,
   parameter int LEVEL_BITS = 6,
   parameter int POOL_SIZE  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  htw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output htw_pkg::rsp_type rsp_data
);
   import htw_pkg::*;
   `include "hierarchical_timer_wheel_assert.svh"

   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int IW = $clog2(POOL_SIZE);
   localparam logic [IW-1:0] LAST_ID = IW'(POOL_SIZE - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_EVAL, S_SEND, S_NEXTLVL, S_EMPTY
   } state_type;

   state_type state_ff;
   logic [LEVEL_BITS-1:0] pos_ff [NUM_LEVELS];
   logic [POOL_SIZE-1:0]  busy_ff;
   logic [31:0]           now_ff;
   logic [LW-1:0]         lvl_ff;
   logic [IW-1:0]         idx_ff;
   logic [LEVEL_BITS-1:0] cur_ff;
   logic                  wrap_ff;
   logic                  any_ff;
   logic                  rv_ff;
   rsp_type               rsp_ff;
   logic [IW-1:0]         pend_id_ff;

   // Entry memory: level, slot and deadline packed per entry.
   logic [LW+LEVEL_BITS+31:0] mem [POOL_SIZE];
   logic [LW+LEVEL_BITS+31:0] rd_ff;
   logic                      we;
   logic [IW-1:0]             waddr;
   logic [LW+LEVEL_BITS+31:0] wdata;

   // Placement of a tick count; shared by add and cascade.
   logic [31:0]           pl_ticks;
   logic                  pl_ok;
   logic [LW-1:0]         pl_lvl;
   logic [LEVEL_BITS-1:0] pl_slot;

   always_comb begin
      logic [31:0] steps;
      pl_ok   = 1'b0;
      pl_lvl  = '0;
      pl_slot = '0;
      steps   = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (LEVEL_BITS * (l + 1) >= 32 || (pl_ticks >> (LEVEL_BITS * (l + 1))) == 0) begin
            pl_ok  = 1'b1;
            pl_lvl = LW'(l);
            steps  = pl_ticks >> (LEVEL_BITS * l);
            if (l == 0)
               pl_slot = pos_ff[0] + steps[LEVEL_BITS-1:0];
            else
               pl_slot = pos_ff[l] + steps[LEVEL_BITS-1:0] - 1'b1;
         end
      end
   end

   logic [LW-1:0]         rd_lvl;
   logic [LEVEL_BITS-1:0] rd_slot;
   logic [31:0]           rd_dl;
   logic [31:0]           left;
   logic                  hit;
   logic                  due;
   logic                  expire;
   logic                  out_free;
   logic                  rsp_load;
   assign {rd_lvl, rd_slot, rd_dl} = rd_ff;
   assign left = rd_dl - now_ff;
   assign hit  = busy_ff[idx_ff] && rd_lvl == lvl_ff && rd_slot == cur_ff;
   assign due  = left == 32'd0 || left[31];
   // Expire on level 0, when due, or when the remaining ticks fit no level.
   assign expire = hit && (lvl_ff == '0 || due || !pl_ok);

   always_comb begin
      pl_ticks = (state_ff == S_IDLE) ? 32'(req_data.delay_ticks) : left;
      we    = 1'b0;
      waddr = idx_ff;
      wdata = {pl_lvl, pl_slot, left};
      if (state_ff == S_IDLE && req_valid && !rv_ff && req_data.mode == MODE_ADD &&
          pl_ok && 32'(req_data.timer_id) < 32'(POOL_SIZE)) begin
         we    = 1'b1;
         waddr = req_data.timer_id[IW-1:0];
         wdata = {pl_lvl, pl_slot, now_ff + 32'(req_data.delay_ticks)};
      end else if (state_ff == S_EVAL && hit && !expire) begin
         we    = 1'b1;
         wdata = {pl_lvl, pl_slot, rd_dl};
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[idx_ff];
   end

   assign req_stall = state_ff != S_IDLE || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // The output register is free when empty or when its transaction is taken now.
   assign out_free = !rv_ff || !rsp_stall;
   assign rsp_load = (state_ff == S_IDLE && req_valid && !rv_ff &&
                      (req_data.mode == MODE_ADD || req_data.mode == MODE_DELETE)) ||
                     (state_ff == S_SEND && any_ff && out_free) ||
                     (state_ff == S_EMPTY && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= '0;
         now_ff   <= '0;
         rv_ff    <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) pos_ff[l] <= '0;
      end else begin
         if (rv_ff && !rsp_stall && !rsp_load) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !rv_ff) begin
                  unique case (req_data.mode)
                     MODE_ADD: begin
                        rv_ff <= 1'b1;
                        rsp_ff.expired_id <= req_data.timer_id;
                        rsp_ff.is_last <= 1'b1;
                        if (32'(req_data.timer_id) < 32'(POOL_SIZE) && pl_ok) begin
                           busy_ff[req_data.timer_id[IW-1:0]] <= 1'b1;
                           rsp_ff.kind <= KIND_DONE;
                        end else rsp_ff.kind <= KIND_REJECTED;
                     end
                     MODE_DELETE: begin
                        rv_ff <= 1'b1;
                        rsp_ff.expired_id <= req_data.timer_id;
                        rsp_ff.is_last <= 1'b1;
                        if (32'(req_data.timer_id) < 32'(POOL_SIZE) &&
                            busy_ff[req_data.timer_id[IW-1:0]]) begin
                           busy_ff[req_data.timer_id[IW-1:0]] <= 1'b0;
                           rsp_ff.kind <= KIND_DONE;
                        end else rsp_ff.kind <= KIND_IDLE;
                     end
                     MODE_TICK: begin
                        now_ff  <= now_ff + 32'd1;
                        cur_ff  <= pos_ff[0];
                        pos_ff[0] <= pos_ff[0] + 1'b1;
                        wrap_ff <= &pos_ff[0];
                        lvl_ff  <= '0;
                        idx_ff  <= '0;
                        any_ff  <= 1'b0;
                        state_ff <= S_RD;
                     end
                     default: ;
                  endcase
               end
            end
            S_RD: state_ff <= S_EVAL;
            S_EVAL: begin
               if (expire) begin
                  busy_ff[idx_ff] <= 1'b0;
                  state_ff <= S_SEND;
               end else if (idx_ff == LAST_ID) state_ff <= S_NEXTLVL;
               else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_SEND: begin
               // Hold the newest expired id back and send the one before it,
               // so the last of the tick can carry is_last.
               if (!any_ff || out_free) begin
                  if (any_ff) begin
                     rv_ff <= 1'b1;
                     rsp_ff <= '{KIND_EXPIRED, 6'(pend_id_ff), 1'b0};
                  end
                  pend_id_ff <= idx_ff;
                  any_ff <= 1'b1;
                  if (idx_ff == LAST_ID) state_ff <= S_NEXTLVL;
                  else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= S_RD;
                  end
               end
            end
            S_NEXTLVL: begin
               if (wrap_ff && 32'(lvl_ff) < NUM_LEVELS - 1) begin
                  cur_ff  <= pos_ff[lvl_ff + 1'b1];
                  pos_ff[lvl_ff + 1'b1] <= pos_ff[lvl_ff + 1'b1] + 1'b1;
                  wrap_ff <= &pos_ff[lvl_ff + 1'b1];
                  lvl_ff  <= lvl_ff + 1'b1;
                  idx_ff  <= '0;
                  state_ff <= S_RD;
               end else state_ff <= S_EMPTY;
            end
            S_EMPTY: begin
               // Send the held expiry as the last one, or the empty-tick result.
               if (out_free) begin
                  rv_ff <= 1'b1;
                  if (any_ff) rsp_ff <= '{KIND_EXPIRED, 6'(pend_id_ff), 1'b1};
                  else rsp_ff <= '{KIND_NONE, 6'd0, 1'b1};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `HTW_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, req_stall, "accept while busy")
   `HTW_ASSERT_NEXT(a_tick_counts, clock, reset, req_valid && !req_stall && req_data.mode == MODE_TICK, now_ff == $past(now_ff) + 32'd1, "tick count")
   `HTW_ASSERT_IMP(a_last_exp, clock, reset, state_ff == S_SEND, !(rv_ff && rsp_ff.kind == KIND_NONE), "empty mark mid tick")
endmodule
